/* rtl/rphi_pkg.sv */
// package: types, constants and helpers for the base-phi digit expander
`timescale 1ns / 1ps

package rphi_pkg;

  localparam int NUM_W            = 24;
  localparam int DIGIT_BITS       = 48;
  localparam int MAX_RATIO        = 6;
  localparam int DATA_W           = 32;
  localparam int DEF_TOP_POWER    = 3;
  localparam int DEF_BOTTOM_POWER = -44;

  typedef struct packed {
    logic [NUM_W-1:0] numerator;
    logic [NUM_W-1:0] denominator;
  } req_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digits;
    logic                  error;
  } res_t;

  // fibonacci number, fib(0) = 0, fib(1) = 1
  function automatic int fib(input int n);
    int f0;
    int f1;
    int t;
    f0 = 0;
    f1 = 1;
    for (int i = 0; i < n; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

endpackage

/* rtl/rational_to_base_phi_digits.sv */
// top level: greedy base-phi digit expander for a rational request
`timescale 1ns / 1ps

// Expands numerator/denominator into greedy base-phi digits for powers
// phi^TOP_POWER down to phi^BOTTOM_POWER, bit i of digits weighing
// phi^(i + BOTTOM_POWER). A request is taken when start is high and busy is
// low. A zero denominator or a value above six never raises busy and answers
// in the cycle after the request with error set and zero digits. Any other
// request holds busy high until the result is shown and runs one range test,
// answering with error set if that fails, then TOP_POWER - BOTTOM_POWER + 1
// digit tests in turn. Each test is decided in ST_EVAL when the sign is plain
// from the operands, else via ST_EVAL, ST_MULV and ST_CMP with the shared
// DATA_W x DATA_W squarer used twice (once for (2u+v)^2, once for v^2) and a
// compare. The result appears on res_o, marked by done_o for exactly one
// cycle, and cannot be held off, so it must be captured in that cycle.
module rational_to_base_phi_digits #(
  parameter int TOP_POWER    = rphi_pkg::DEF_TOP_POWER,
  parameter int BOTTOM_POWER = rphi_pkg::DEF_BOTTOM_POWER
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rphi_pkg::req_t req_i,
  output logic           done_o,
  output rphi_pkg::res_t res_o
);

  localparam int W      = rphi_pkg::DATA_W;
  localparam int NW     = rphi_pkg::NUM_W;
  localparam int DB     = rphi_pkg::DIGIT_BITS;
  localparam int STEPS  = TOP_POWER - BOTTOM_POWER;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int F_TOP  = rphi_pkg::fib(TOP_POWER);
  localparam int F_NEXT = rphi_pkg::fib(TOP_POWER + 1);

  // num * phi^-TOP_POWER = num * (-1)^TOP_POWER * (F(T+1) - F(T) * phi)
  localparam logic signed [W-1:0] A_COEF = W'((TOP_POWER % 2 == 0) ? F_NEXT : -F_NEXT);
  localparam logic signed [W-1:0] B_COEF = W'((TOP_POWER % 2 == 0) ? -F_TOP : F_TOP);
  localparam logic signed [W-1:0] F_TOP_C  = W'(F_TOP);
  localparam logic signed [W-1:0] F_NEXT_C = W'(F_NEXT);
  localparam logic [NW+2:0]       RATIO_C  = (NW+3)'(rphi_pkg::MAX_RATIO);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_MULV = 2'd2;
  localparam logic [1:0] ST_CMP  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  pre_q, pre_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [W-1:0]   a_q, a_d;
  logic signed [W-1:0]   b_q, b_d;
  logic signed [W-1:0]   u_q, u_d;
  logic signed [W-1:0]   v_q, v_d;
  logic [NW-1:0]         den_q, den_d;
  logic [2*W-1:0]        prod_q, prod_d;
  logic [2*W-1:0]        ss_q, ss_d;
  logic [DB-1:0]         digits_q, digits_d;
  logic                  err_q, err_d;

  logic signed [W-1:0]   num_ext;
  logic signed [W-1:0]   rnum_ext;
  logic signed [W-1:0]   rden_ext;
  logic signed [W-1:0]   den_ext;
  logic [NW+2:0]         six_den;
  logic signed [W+1:0]   s_w;
  logic signed [W+1:0]   s_neg_w;
  logic signed [W-1:0]   v_neg_w;
  logic [W-1:0]          s_mag;
  logic [W-1:0]          v_mag;
  logic [W-1:0]          mul_x;
  logic [2*W+2:0]        five_v;
  logic                  s_big;
  logic                  v_zero, v_neg, s_neg, s_zero;
  logic                  plain_hit, plain_ge, cmp_ge;
  logic                  dec_go, dec_ge;
  logic signed [W-1:0]   a_sub, b_new;

  assign rnum_ext = W'({1'b0, req_i.numerator});
  assign rden_ext = W'({1'b0, req_i.denominator});
  assign num_ext  = rnum_ext;
  assign den_ext  = W'({1'b0, den_q});
  assign six_den  = RATIO_C * (NW+3)'(req_i.denominator);

  // sign test on u + v*phi through (2u+v)^2 against 5v^2
  assign s_w     = {u_q[W-1], u_q, 1'b0} + {{2{v_q[W-1]}}, v_q};
  assign s_neg_w = -s_w;
  assign v_neg_w = -v_q;
  assign s_mag   = s_w[W+1] ? s_neg_w[W-1:0] : s_w[W-1:0];
  assign v_mag   = v_q[W-1] ? v_neg_w : v_q;
  assign mul_x   = (state_q == ST_EVAL) ? s_mag : v_mag;
  assign prod_d  = mul_x * mul_x;

  assign v_zero = (v_q == '0);
  assign v_neg  = v_q[W-1];
  assign s_neg  = s_w[W+1];
  assign s_zero = (s_w == '0);

  assign plain_hit = v_zero || (!v_neg && !s_neg) || (v_neg && (s_neg || s_zero));
  assign plain_ge  = v_zero ? !s_neg : !v_neg;

  assign five_v = {3'b000, prod_q} + {1'b0, prod_q, 2'b00};
  assign s_big  = ({3'b000, ss_q} > five_v);
  assign cmp_ge = v_neg ? s_big : !s_big;

  assign dec_go = ((state_q == ST_EVAL) && plain_hit) || (state_q == ST_CMP);
  assign dec_ge = (state_q == ST_CMP) ? cmp_ge : plain_ge;

  assign a_sub = dec_ge ? (a_q - den_ext) : a_q;
  assign b_new = a_sub + b_q;

  always_comb begin
    state_d  = state_q;
    pre_d    = pre_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    u_d      = u_q;
    v_d      = v_q;
    den_d    = den_q;
    ss_d     = ss_q;
    digits_d = digits_q;
    err_d    = err_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          den_d    = req_i.denominator;
          digits_d = '0;
          err_d    = 1'b0;
          pre_d    = 1'b1;
          cnt_d    = CNT_W'(STEPS);
          a_d      = num_ext * A_COEF;
          b_d      = num_ext * B_COEF;
          u_d      = rnum_ext - rden_ext * F_TOP_C;
          v_d      = -(rden_ext * F_NEXT_C);
          if ((req_i.denominator == '0) || ((NW+3)'(req_i.numerator) > six_den)) begin
            err_d  = 1'b1;
            done_d = 1'b1;
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (!plain_hit) begin
          state_d = ST_MULV;
        end
      end
      ST_MULV: begin
        ss_d    = prod_q;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_EVAL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (dec_go) begin
      state_d = ST_EVAL;
      if (pre_q) begin
        pre_d = 1'b0;
        if (dec_ge) begin
          err_d   = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          u_d = a_q - den_ext;
          v_d = b_q;
        end
      end else begin
        if (dec_ge) begin
          digits_d = digits_q | (DB'(1) << cnt_q);
        end
        a_d = b_q;
        b_d = b_new;
        u_d = b_q - den_ext;
        v_d = b_new;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pre_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pre_q   <= pre_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    u_q      <= u_d;
    v_q      <= v_d;
    den_q    <= den_d;
    prod_q   <= prod_d;
    ss_q     <= ss_d;
    digits_q <= digits_d;
    err_q    <= err_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign res_o.digits = err_q ? '0 : digits_q;
  assign res_o.error  = err_q;

`ifndef SYNTH
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.error) |-> (res_o.digits == '0))
    else $error("error result carries digits");

  a_no_adjacent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.digits & (res_o.digits >> 1)) == '0))
    else $error("adjacent ones in greedy digits");

  a_pre_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !$past(busy)) |=> (!busy || pre_q))
    else $error("digit loop entered without range test");
`endif

endmodule

/* test/phi_digits_checker.sv */
// checker: predicts the greedy base-phi digits of each accepted request and compares results
`timescale 1ns / 1ps

module phi_digits_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  rphi_pkg::req_t req_i,
  input  logic           done_i,
  input  rphi_pkg::res_t res_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             checked_o,
  output int             rejected_o
);

  localparam int TOP        = rphi_pkg::DEF_TOP_POWER;
  localparam int BOTTOM     = rphi_pkg::DEF_BOTTOM_POWER;
  localparam int MAX_RATIO  = rphi_pkg::MAX_RATIO;
  localparam int DIGIT_BITS = rphi_pkg::DIGIT_BITS;

  typedef struct {
    rphi_pkg::req_t request;
    rphi_pkg::res_t digits;
  } awaited_t;

  awaited_t awaited_digits_q[$];

  // sign of u + v*phi, exact: 2(u + v*phi) = (2u+v) + v*sqrt5
  function automatic int phi_sign(longint u, longint v);
    longint       s;
    logic [63:0]  s_mag;
    logic [63:0]  v_mag;
    logic [127:0] s_sq;
    logic [127:0] v_sq;
    s = 2 * u + v;
    if (v == 0) return (s > 0) ? 1 : ((s < 0) ? -1 : 0);
    if (v > 0 && s >= 0) return 1;
    if (v < 0 && s <= 0) return -1;
    s_mag = (s < 0) ? -s : s;
    v_mag = (v < 0) ? -v : v;
    s_sq  = 128'(s_mag) * 128'(s_mag);
    v_sq  = 128'(5) * 128'(v_mag) * 128'(v_mag);
    if (v > 0) return (s_sq > v_sq) ? -1 : 1;
    return (s_sq > v_sq) ? 1 : -1;
  endfunction

  function automatic rphi_pkg::res_t expand_phi(rphi_pkg::req_t r);
    rphi_pkg::res_t res;
    longint         num;
    longint         den;
    longint         a;
    longint         b;
    longint         t;
    longint         f_lo;
    longint         f_hi;
    int             k;
    res.digits = '0;
    res.error  = 1'b1;
    num = r.numerator;
    den = r.denominator;
    if (den == 0 || num > MAX_RATIO * den) return res;
    f_lo = 0;
    f_hi = 1;
    for (k = 0; k < TOP; k++) begin
      t    = f_lo + f_hi;
      f_lo = f_hi;
      f_hi = t;
    end
    // value must stay below phi^(TOP+1)
    if (phi_sign(num - den * f_lo, -den * f_hi) >= 0) return res;
    // scale by phi^-TOP, using 1/phi = phi - 1
    a = num;
    b = 0;
    for (k = 0; k < TOP; k++) begin
      t = b - a;
      b = a;
      a = t;
    end
    for (k = TOP - BOTTOM; k >= 0; k--) begin
      if (phi_sign(a - den, b) >= 0) begin
        a = a - den;
        if (k < DIGIT_BITS) res.digits[k] = 1'b1;
      end
      t = a + b;
      a = b;
      b = t;
    end
    res.error = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    awaited_t head;
    awaited_t entry;
    int       fails;
    fails = 0;
    if (!rst_ni) begin
      awaited_digits_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      rejected_o   <= 0;
    end else begin
      if (done_i) begin
        if (awaited_digits_q.size() == 0) begin
          $display("%0t: result with no request outstanding: digits %h error %b",
                   $time, res_i.digits, res_i.error);
          fails++;
        end else begin
          head = awaited_digits_q.pop_front();
          if (res_i.digits !== head.digits.digits) begin
            $display("%0t: digits for %0d/%0d: expected %h actual %h", $time,
                     head.request.numerator, head.request.denominator,
                     head.digits.digits, res_i.digits);
            fails++;
          end
          if (res_i.error !== head.digits.error) begin
            $display("%0t: error flag for %0d/%0d: expected %b actual %b", $time,
                     head.request.numerator, head.request.denominator,
                     head.digits.error, res_i.error);
            fails++;
          end
          checked_o  <= checked_o + 1;
          rejected_o <= rejected_o + int'(head.digits.error);
        end
      end
      if (start_i && !busy_i) begin
        entry.request = req_i;
        entry.digits  = expand_phi(req_i);
        awaited_digits_q.push_back(entry);
      end
      fail_count_o <= fail_count_o + fails;
      pending_o    <= awaited_digits_q.size();
    end
  end

endmodule

/* test/rational_to_base_phi_digits_test.sv */
// testbench top: drives rational requests into the base-phi expander and gives the verdict
`timescale 1ns / 1ps

module rational_to_base_phi_digits_test;

  localparam int             NUM_W           = rphi_pkg::NUM_W;
  localparam int             MAX_RATIO       = rphi_pkg::MAX_RATIO;
  localparam int             RANDOM_REQUESTS = 1630;
  localparam int             CYCLE_LIMIT     = 2_000_000;
  localparam int             SETTLE_CYCLES   = 200;
  localparam logic [NUM_W-1:0] FIELD_MAX     = '1;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  logic           busy;
  rphi_pkg::req_t req_i  = '0;
  logic           done_o;
  rphi_pkg::res_t res_o;

  int fail_count;
  int pending;
  int checked;
  int rejected;
  int cycles = 0;
  int sent   = 0;

  rphi_pkg::req_t directed_q[$];

  rational_to_base_phi_digits u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  phi_digits_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .done_i      (done_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .rejected_o  (rejected)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 80) return $urandom_range(1, 4);
    if (sel < 95) return $urandom_range(5, 60);
    return $urandom_range(100, 300);
  endfunction

  function automatic rphi_pkg::req_t random_request();
    rphi_pkg::req_t r;
    int unsigned    sel;
    int unsigned    hi;
    sel           = $urandom_range(0, 99);
    r.numerator   = NUM_W'($urandom());
    r.denominator = NUM_W'($urandom());
    if (sel < 45) begin
      if (r.denominator == 0) r.denominator = 1;
      hi = MAX_RATIO * r.denominator;
      if (hi > FIELD_MAX) hi = FIELD_MAX;
      r.numerator = NUM_W'($urandom_range(0, hi));
    end else if (sel < 60) begin
      r.denominator = NUM_W'($urandom_range(1, 255));
      r.numerator   = NUM_W'($urandom_range(0, MAX_RATIO * r.denominator));
    end else if (sel < 70) begin
      r.denominator = NUM_W'($urandom_range(1, 4095));
      r.numerator   = NUM_W'($urandom_range(0, MAX_RATIO * r.denominator));
    end else if (sel < 78) begin
      // right at or just past the limit of six
      r.denominator = NUM_W'($urandom_range(1, FIELD_MAX / MAX_RATIO));
      r.numerator   = NUM_W'(MAX_RATIO * r.denominator + $urandom_range(0, 1));
    end else if (sel < 83) begin
      r.denominator = '0;
    end else if (sel < 88) begin
      r.numerator = '0;
    end
    return r;
  endfunction

  task automatic issue(rphi_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned    gap;
    rphi_pkg::req_t r;
    directed_q.push_back('{24'd0, 24'd1});
    directed_q.push_back('{24'd0, 24'd0});
    directed_q.push_back('{24'd5, 24'd0});
    directed_q.push_back('{FIELD_MAX, 24'd0});
    directed_q.push_back('{24'd1, 24'd1});
    directed_q.push_back('{24'd2, 24'd1});
    directed_q.push_back('{24'd3, 24'd1});
    directed_q.push_back('{24'd4, 24'd1});
    directed_q.push_back('{24'd6, 24'd1});
    directed_q.push_back('{24'd7, 24'd1});
    directed_q.push_back('{FIELD_MAX, 24'd1});
    directed_q.push_back('{24'd1, FIELD_MAX});
    directed_q.push_back('{FIELD_MAX, FIELD_MAX});
    directed_q.push_back('{24'd0, FIELD_MAX});
    directed_q.push_back('{24'd16777212, 24'd2796202});
    directed_q.push_back('{24'd16777213, 24'd2796202});
    directed_q.push_back('{FIELD_MAX, 24'd2796203});
    directed_q.push_back('{24'd5, 24'd3});
    directed_q.push_back('{24'hAAAAAA, 24'h555555});
    directed_q.push_back('{24'h555555, 24'hAAAAAA});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < directed_q.size() + RANDOM_REQUESTS; k++) begin
      gap = (k == 0) ? 0 : idle_length();
      if (gap != 0) begin
        start <= 1'b0;
        req_i <= random_request();
        repeat (gap) @(posedge clk_i);
      end
      // let the block run dry now and then before the next request
      if (k == directed_q.size() || $urandom_range(0, 99) == 0) drain();
      r = (k < directed_q.size()) ? directed_q[k] : random_request();
      issue(r);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests sent (%0d hand-picked corner cases), %0d results checked",
             sent, directed_q.size(), checked);
    $display("%0d of those results were rejections", rejected);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
